// ----- hdl/nsf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nsf_pkg;

    localparam int FLUX_W     = 24;
    localparam int SRCH_BITS  = FLUX_W + 1;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0]  REG_ONLY_INCREASE = 8'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_BINS_IN_USE   = 8'd1;
    localparam logic [CFG_DATA_W-1:0] BINS_RESET        = 11'd512;

    typedef enum logic [8:0] {
        ST_ACCUM     = 9'b000000001,
        ST_DRAIN     = 9'b000000010,
        ST_LATCH     = 9'b000000100,
        ST_MUL_PC    = 9'b000001000,
        ST_MUL_MID   = 9'b000010000,
        ST_MUL_DD    = 9'b000100000,
        ST_SRCH_INIT = 9'b001000000,
        ST_SEARCH    = 9'b010000000,
        ST_OUTPUT    = 9'b100000000
    } state_t;

    typedef struct packed {
        logic in_fire;
        logic load;
        logic mul_step;
        logic mul_mid;
        logic srch_init;
        logic srch_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } ctrl_stat_t;

endpackage

`default_nettype wire

// ----- hdl/nsf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nsf_ctrl #(
    parameter int MAX_BINS  = 1024,
    parameter int BIN_WIDTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            cfg_valid,
    input  wire logic [nsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [nsf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                 only_increase,
    output logic [$clog2(MAX_BINS)-1:0]          bin_pos,
    output nsf_pkg::ctrl_cmd_t                   cmd,
    input  nsf_pkg::ctrl_stat_t                  stat
);

    localparam int IW     = $clog2(MAX_BINS);
    localparam int AW_RAW = 2 * BIN_WIDTH + IW;
    localparam int ACC_W  = (AW_RAW > 64) ? 64 : AW_RAW;
    localparam int CW     = (IW + 1 > nsf_pkg::CFG_DATA_W) ? IW + 1 : nsf_pkg::CFG_DATA_W;

    nsf_pkg::state_t                state_reg, state_next;
    logic [nsf_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [IW-1:0]                  bin_index_reg, bin_index_next;
    logic                           only_inc_reg;
    logic [nsf_pkg::CFG_DATA_W-1:0] bins_reg;
    logic [CW-1:0]                  len_raw, len_eff, pos_inc;
    logic                           last_bin;
    logic                           in_fire;

    assign in_ready      = (state_reg == nsf_pkg::ST_ACCUM);
    assign in_fire       = in_valid && in_ready;
    assign only_increase = only_inc_reg;
    assign bin_pos       = bin_index_reg;

    // frame length of zero acts as one, above the store depth as the depth
    always_comb
    begin
        len_raw = CW'(bins_reg);
        if (len_raw == '0)
            len_eff = CW'(1);
        else if (len_raw > CW'(MAX_BINS))
            len_eff = CW'(MAX_BINS);
        else
            len_eff = len_raw;
        pos_inc  = CW'(bin_index_reg) + CW'(1);
        last_bin = (pos_inc >= len_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            only_inc_reg <= 1'b0;
            bins_reg     <= nsf_pkg::BINS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                nsf_pkg::REG_ONLY_INCREASE: only_inc_reg <= cfg_data[0];
                nsf_pkg::REG_BINS_IN_USE:   bins_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bin_index_next = bin_index_reg;
        cmd            = '0;
        cmd.in_fire    = in_fire;
        unique case (state_reg)
            nsf_pkg::ST_ACCUM:
            begin
                if (in_fire)
                begin
                    if (last_bin)
                    begin
                        bin_index_next = '0;
                        state_next     = nsf_pkg::ST_DRAIN;
                    end
                    else
                        bin_index_next = bin_index_reg + IW'(1);
                end
            end
            nsf_pkg::ST_DRAIN:
                state_next = nsf_pkg::ST_LATCH;
            nsf_pkg::ST_LATCH:
            begin
                cmd.load   = 1'b1;
                cnt_next   = nsf_pkg::CNT_W'(ACC_W - 1);
                state_next = nsf_pkg::ST_MUL_PC;
            end
            nsf_pkg::ST_MUL_PC:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = nsf_pkg::ST_MUL_MID;
            end
            nsf_pkg::ST_MUL_MID:
            begin
                cmd.mul_mid = 1'b1;
                cnt_next    = nsf_pkg::CNT_W'(ACC_W - 1);
                state_next  = nsf_pkg::ST_MUL_DD;
            end
            nsf_pkg::ST_MUL_DD:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = nsf_pkg::ST_SRCH_INIT;
            end
            nsf_pkg::ST_SRCH_INIT:
            begin
                cmd.srch_init = 1'b1;
                cnt_next      = nsf_pkg::CNT_W'(nsf_pkg::SRCH_BITS - 1);
                state_next    = nsf_pkg::ST_SEARCH;
            end
            nsf_pkg::ST_SEARCH:
            begin
                cmd.srch_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = nsf_pkg::ST_OUTPUT;
            end
            nsf_pkg::ST_OUTPUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = nsf_pkg::ST_ACCUM;
                end
            end
            default:
                state_next = nsf_pkg::ST_ACCUM;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nsf_pkg::ST_ACCUM;
            cnt_reg       <= '0;
            bin_index_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bin_index_reg <= bin_index_next;
        end
    end

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_bin) |=> (state_reg == nsf_pkg::ST_DRAIN))
        else $error("last bin of frame did not start the back end");

    a_search_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nsf_pkg::ST_SEARCH) |-> (cnt_reg < nsf_pkg::CNT_W'(nsf_pkg::SRCH_BITS)))
        else $error("search counter out of range");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over a beat not yet taken");

endmodule

`default_nettype wire

// ----- hdl/nsf_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nsf_datapath #(
    parameter int MAX_BINS  = 1024,
    parameter int BIN_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [BIN_WIDTH-1:0]   bin_value,
    input  wire logic [$clog2(MAX_BINS)-1:0]   bin_pos,
    input  wire logic                          only_increase,
    input  nsf_pkg::ctrl_cmd_t                 cmd,
    output nsf_pkg::ctrl_stat_t                stat,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [nsf_pkg::FLUX_W-1:0]         flux_value,
    output logic                               saturated
);

    localparam int BW     = BIN_WIDTH;
    localparam int IW     = $clog2(MAX_BINS);
    localparam int AW_RAW = 2 * BW + IW;
    localparam int ACC_W  = (AW_RAW > 64) ? 64 : AW_RAW;
    localparam int PW     = 2 * ACC_W;
    localparam int LW     = PW + 52;
    localparam int QB     = nsf_pkg::SRCH_BITS;

    logic signed [BW-1:0] mem [MAX_BINS];
    logic signed [BW-1:0] rdata_reg;
    logic                 rvalid_reg;
    logic [IW:0]          fill_reg;

    logic                 s1_valid_reg;
    logic [IW-1:0]        s1_pos_reg;
    logic signed [BW-1:0] s1_cur_reg;

    logic [ACC_W-1:0] diff_sum_reg, cur_norm_reg, prev_norm_reg, dd_src_reg;
    logic             zero_reg;
    logic [PW-1:0]    ma_reg, mp_reg, pc_reg;
    logic [ACC_W-1:0] mb_reg;
    logic [LW-1:0]    rhs_reg, lhs_reg, a_reg, b_reg;
    logic [QB-1:0]    q_reg;

    logic [nsf_pkg::FLUX_W-1:0] flux_reg;
    logic                       sat_reg, out_valid_reg;

    logic signed [BW-1:0] prev_bin;
    logic signed [BW:0]   diff, dmag, cmag;
    logic [2*BW-1:0]      dsq, csq;
    logic                 count_diff;
    logic [LW-1:0]        cand, a_acc;
    logic                 fits;

    // entries at or above the fill mark were never written and read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.in_fire)
            rdata_reg <= mem[bin_pos];
        if (s1_valid_reg)
            mem[s1_pos_reg] <= s1_cur_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            rvalid_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.in_fire;
            if (cmd.in_fire)
                rvalid_reg <= ({1'b0, bin_pos} < fill_reg);
            if (s1_valid_reg && ({1'b0, s1_pos_reg} >= fill_reg))
                fill_reg <= {1'b0, s1_pos_reg} + (IW + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_fire)
        begin
            s1_pos_reg <= bin_pos;
            s1_cur_reg <= bin_value;
        end
    end

    always_comb
    begin
        prev_bin   = rvalid_reg ? rdata_reg : '0;
        diff       = {s1_cur_reg[BW-1], s1_cur_reg} - {prev_bin[BW-1], prev_bin};
        dmag       = diff[BW] ? -diff : diff;
        cmag       = s1_cur_reg[BW-1] ? -{s1_cur_reg[BW-1], s1_cur_reg}
                                      : {s1_cur_reg[BW-1], s1_cur_reg};
        dsq        = dmag[BW-1:0] * dmag[BW-1:0];
        csq        = cmag[BW-1:0] * cmag[BW-1:0];
        count_diff = !only_increase || (!diff[BW] && (diff != '0));
    end

    // greedy bit search: lhs = q^2*P*C, a = q*P*C*2^(k+1), b = P*C*2^(2k)
    always_comb
    begin
        cand  = lhs_reg + a_reg + b_reg;
        fits  = (cand <= rhs_reg);
        a_acc = a_reg + (b_reg << 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_sum_reg  <= '0;
            cur_norm_reg  <= '0;
            prev_norm_reg <= '0;
        end
        else if (cmd.load)
        begin
            prev_norm_reg <= cur_norm_reg;
            cur_norm_reg  <= '0;
            diff_sum_reg  <= '0;
        end
        else if (s1_valid_reg)
        begin
            cur_norm_reg <= cur_norm_reg + ACC_W'(csq);
            if (count_diff)
                diff_sum_reg <= diff_sum_reg + ACC_W'(dsq);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dd_src_reg <= diff_sum_reg;
            zero_reg   <= (prev_norm_reg == '0) || (cur_norm_reg == '0);
            ma_reg     <= PW'(prev_norm_reg);
            mb_reg     <= cur_norm_reg;
            mp_reg     <= '0;
        end
        else if (cmd.mul_mid)
        begin
            pc_reg <= mp_reg;
            ma_reg <= PW'(dd_src_reg);
            mb_reg <= dd_src_reg;
            mp_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (mb_reg[0])
                mp_reg <= mp_reg + ma_reg;
            ma_reg <= ma_reg << 1;
            mb_reg <= mb_reg >> 1;
        end

        if (cmd.srch_init)
        begin
            rhs_reg <= LW'(mp_reg) << 32;
            b_reg   <= LW'(pc_reg) << (2 * (QB - 1));
            a_reg   <= '0;
            lhs_reg <= '0;
            q_reg   <= '0;
        end
        else if (cmd.srch_step)
        begin
            if (fits)
                lhs_reg <= cand;
            a_reg <= fits ? (a_acc >> 1) : (a_reg >> 1);
            b_reg <= b_reg >> 2;
            q_reg <= {q_reg[QB-2:0], fits};
        end

        if (cmd.out_load)
        begin
            if (zero_reg)
                flux_reg <= '0;
            else if (q_reg[QB-1])
                flux_reg <= '1;
            else
                flux_reg <= q_reg[nsf_pkg::FLUX_W-1:0];
            sat_reg <= !zero_reg && q_reg[QB-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign flux_value    = flux_reg;
    assign saturated     = sat_reg;

endmodule

`default_nettype wire

// ----- hdl/normalized_spectral_flux.sv -----
// channel   direction  beat contents (low bit first)          handshake
// s_axis    in         tdata: bin_value                       s_axis_tvalid/s_axis_tready
// m_axis    out        tdata: flux_value, tuser: saturated    m_axis_tvalid/m_axis_tready
// cfg       in         cfg_index, cfg_data                    cfg_valid/cfg_ready
//
// one bin per cycle inside a frame; the bin store is read one cycle and written the next
// at frame end the serial back end runs two shift-add products of ACC_W steps each, a
// 25-step bit search for the quotient and the drain, latch, mid, search-init and output
// steps, input held off meanwhile
// a finished result waits in the output register while the next frame streams in; if it
// is still untaken when the next frame ends, the back end holds its result and the input
// after reset the store reads as zero above a fill mark, so no clearing pass is needed
// config writes are always taken
`timescale 1ns / 1ps
`default_nettype none

module normalized_spectral_flux #(
    parameter int MAX_BINS  = 1024,
    parameter int BIN_WIDTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // bin_value
    input  wire logic [((BIN_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // flux_value
    output logic [nsf_pkg::FLUX_W-1:0]            m_axis_tdata,
    // saturated
    output logic                                  m_axis_tuser,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [nsf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nsf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    nsf_pkg::ctrl_cmd_t            cmd;
    nsf_pkg::ctrl_stat_t           stat;
    logic                          only_increase;
    logic [$clog2(MAX_BINS)-1:0]   bin_pos;
    logic signed [BIN_WIDTH-1:0]   bin_value;

    assign cfg_ready = 1'b1;
    assign bin_value = s_axis_tdata[BIN_WIDTH-1:0];

    nsf_ctrl #(
        .MAX_BINS  (MAX_BINS),
        .BIN_WIDTH (BIN_WIDTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .only_increase (only_increase),
        .bin_pos       (bin_pos),
        .cmd           (cmd),
        .stat          (stat)
    );

    nsf_datapath #(
        .MAX_BINS  (MAX_BINS),
        .BIN_WIDTH (BIN_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .bin_value     (bin_value),
        .bin_pos       (bin_pos),
        .only_increase (only_increase),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .flux_value    (m_axis_tdata),
        .saturated     (m_axis_tuser)
    );

endmodule

`default_nettype wire
